@@ rtl/lzfd_pkg.sv @@
package lzfd_pkg;

  localparam int LZ_WINDOW_SIZE = 1024;
  localparam int CNT_W          = 7;   // copy count 2 to 65
  localparam int OFS_W          = 10;  // token offset field
  localparam int COUNT_BIAS     = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       run_last;
  } out_t;

  typedef enum logic [1:0] {
    KIND_FLAG,
    KIND_TOKEN_LOW,
    KIND_TOKEN_HIGH,
    KIND_LITERAL
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;  // input transfer in this cycle
    logic rd;      // issue history read for one copied byte
    logic wr;      // write copied byte back, advance pointer
    logic emit;    // load output register from the pair buffer
    logic finish;  // item done, apply stream-end reset if pending
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  last_byte;
    logic  second_slot;
    logic  out_free;
    logic  done;
  } status_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

@@ rtl/lz_flag_byte_decompressor.sv @@
// Flag-byte LZ decompressor with a sliding history window.
// Input channel: one compressed byte per transfer (flag, literal or token
// byte) with stream_end marking the last byte of a stream. Output channel:
// results of one or two decompressed bytes, run_last on the final result
// caused by one input byte. Both channels use valid/stall handshakes.
// A flag byte or token low byte is finished when accepted; a literal is
// written to the window and then emitted; a token high byte copies its
// bytes one by one and emits them in pairs. Each copied byte costs a history
// read and a write-back on the registered read port of the window RAM, and
// each result a load of the output register. Input is stalled while a byte
// is being worked on. A result passes the pair buffer and then the output
// register; the output register holds a result while the receiver stalls,
// and the copy waits until it is taken.
// At reset and after a stream_end byte the window reads as all zeros: a
// fill pointer marks written slots, so no clearing pass is needed.
module lz_flag_byte_decompressor import lzfd_pkg::*; #(
  parameter int WindowSize = LZ_WINDOW_SIZE
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  // sequence each byte: accept, read/write per copied byte, emit pairs
  lzfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // history window, flag and token registers, pair buffer, output register
  lzfd_datapath #(
    .WindowSize(WindowSize)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  // a write-back always uses the read data issued the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> $past(cmd.rd))
    else $error("copy write without preceding history read");

  // never overwrite a result the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

  // an input transfer happens only while no copy work is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !(cmd.rd || cmd.wr || cmd.emit))
    else $error("input accepted during copy work");

  // every result carries one or two bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_count == 2'd1 || out_data_o.byte_count == 2'd2))
    else $error("bad byte count on output");

endmodule

@@ rtl/lzfd_ram.sv @@
module lzfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lzfd_ctrl.sv @@
module lzfd_ctrl import lzfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.kind) inside
            KIND_LITERAL:                state_d = ST_EMIT;
            KIND_TOKEN_HIGH:             state_d = ST_READ;
            KIND_FLAG, KIND_TOKEN_LOW:   state_d = ST_IDLE;
            default:                     state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (status_i.second_slot || status_i.last_byte) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.done ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_READ:  cmd_o.rd = 1'b1;
      ST_WRITE: cmd_o.wr = 1'b1;
      ST_EMIT: begin
        cmd_o.emit   = status_i.out_free;
        cmd_o.finish = status_i.out_free && status_i.done;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

@@ rtl/lzfd_datapath.sv @@
module lzfd_datapath import lzfd_pkg::*; #(
  parameter int WindowSize = LZ_WINDOW_SIZE
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    out_valid_o,
  output out_t    out_data_o,
  input  logic    out_stall_i
);

  localparam int AW = $clog2(WindowSize);

  logic [8:0]       flag_q, flag_d;
  logic [7:0]       token_low_q, token_low_d;
  logic             expect_q, expect_d;
  logic             end_q, end_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic             full_q, full_d;
  logic [CNT_W-1:0] remain_q, remain_d;
  logic [OFS_W-1:0] offset_q, offset_d;
  logic             phase_q, phase_d;
  logic             hit_q, hit_d;
  out_t             pair_q, pair_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  kind_e         kind;
  logic [AW-1:0] raddr;
  logic [AW-1:0] wp_inc;
  logic [7:0]    rdata;
  logic [7:0]    copy_byte;
  logic          ram_we;
  logic [7:0]    ram_wdata;

  always_comb begin
    if (flag_q == 9'd1) begin
      kind = KIND_FLAG;
    end else if (expect_q) begin
      kind = KIND_TOKEN_HIGH;
    end else if (flag_q[0]) begin
      kind = KIND_LITERAL;
    end else begin
      kind = KIND_TOKEN_LOW;
    end
  end

  assign raddr     = wp_q + AW'(offset_q);
  assign wp_inc    = wp_q + AW'(1);
  assign copy_byte = hit_q ? rdata : 8'd0;
  assign ram_we    = cmd_i.wr || (cmd_i.accept && kind == KIND_LITERAL);
  assign ram_wdata = cmd_i.wr ? copy_byte : in_data_i.in_byte;

  lzfd_ram #(
    .Width(8),
    .Depth(WindowSize)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(ram_wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    flag_d      = flag_q;
    token_low_d = token_low_q;
    expect_d    = expect_q;
    end_d       = end_q;
    wp_d        = wp_q;
    full_d      = full_q;
    remain_d    = remain_q;
    offset_d    = offset_q;
    phase_d     = phase_q;
    hit_d       = hit_q;
    pair_d      = pair_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.accept) begin
      unique case (kind)
        KIND_FLAG: begin
          flag_d = {1'b1, reverse8(in_data_i.in_byte)};
        end
        KIND_TOKEN_LOW: begin
          token_low_d = in_data_i.in_byte;
          expect_d    = 1'b1;
        end
        KIND_TOKEN_HIGH: begin
          remain_d = CNT_W'(in_data_i.in_byte[7:2]) + CNT_W'(COUNT_BIAS);
          offset_d = {in_data_i.in_byte[1:0], token_low_q};
          expect_d = 1'b0;
          flag_d   = flag_q >> 1;
          phase_d  = 1'b0;
          end_d    = in_data_i.stream_end;
        end
        KIND_LITERAL: begin
          wp_d   = wp_inc;
          full_d = full_q || (wp_q == AW'(WindowSize - 1));
          pair_d.first_byte  = in_data_i.in_byte;
          pair_d.second_byte = 8'd0;
          pair_d.byte_count  = 2'd1;
          pair_d.run_last    = 1'b1;
          remain_d = '0;
          flag_d   = flag_q >> 1;
          end_d    = in_data_i.stream_end;
        end
        default: flag_d = flag_q;
      endcase
      // drop a cut-off token or a lone flag byte at stream end
      if (in_data_i.stream_end && (kind == KIND_FLAG || kind == KIND_TOKEN_LOW)) begin
        flag_d   = 9'd1;
        expect_d = 1'b0;
        wp_d     = '0;
        full_d   = 1'b0;
      end
    end

    if (cmd_i.rd) begin
      // unwritten slots since reset read as zero
      hit_d = full_q || (raddr < wp_q);
    end

    if (cmd_i.wr) begin
      wp_d     = wp_inc;
      full_d   = full_q || (wp_q == AW'(WindowSize - 1));
      remain_d = remain_q - CNT_W'(1);
      if (!phase_q) begin
        pair_d.first_byte  = copy_byte;
        pair_d.second_byte = 8'd0;
        pair_d.byte_count  = 2'd1;
        phase_d            = 1'b1;
      end else begin
        pair_d.second_byte = copy_byte;
        pair_d.byte_count  = 2'd2;
        phase_d            = 1'b0;
      end
      pair_d.run_last = (remain_q == CNT_W'(1));
    end

    if (cmd_i.emit) begin
      out_d       = pair_q;
      out_valid_d = 1'b1;
    end

    if (cmd_i.finish && end_q) begin
      flag_d   = 9'd1;
      expect_d = 1'b0;
      wp_d     = '0;
      full_d   = 1'b0;
      end_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q      <= 9'd1;
      expect_q    <= 1'b0;
      end_q       <= 1'b0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      remain_q    <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flag_q      <= flag_d;
      expect_q    <= expect_d;
      end_q       <= end_d;
      wp_q        <= wp_d;
      full_q      <= full_d;
      remain_q    <= remain_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    token_low_q <= token_low_d;
    offset_q    <= offset_d;
    hit_q       <= hit_d;
    pair_q      <= pair_d;
    out_q       <= out_d;
  end

  assign status_o.kind        = kind;
  assign status_o.last_byte   = (remain_q == CNT_W'(1));
  assign status_o.second_slot = phase_q;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;
  assign status_o.done        = (remain_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lzfd_pkg::*;

  localparam int WIN = LZ_WINDOW_SIZE;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  lz_flag_byte_decompressor u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Compressed bytes waiting to go out, and byte pairs the decoder still owes.
  in_t  compressed_bytes[$];
  out_t pending_pairs[$];

  int mismatch_count = 0;

  // Shadow copy of the decoder state.
  logic [7:0] win_hist [WIN];
  logic [9:0] win_ptr;
  logic [8:0] flag_sr;      // flag bits, LSB next, marker bit on top
  logic [7:0] tok_lo;
  logic       want_tok_hi;

  // Handshake bookkeeping, seen by the falling-edge drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   gap_left  = 0;
  int   stall_left = 0;
  bit   calm_in   = 1'b0;
  bit   calm_out  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow decoder
  // ---------------------------------------------------------------------------

  task automatic clear_window();
    for (int i = 0; i < WIN; i++) begin
      win_hist[i] = 8'h00;
    end
    win_ptr     = '0;
    flag_sr     = 9'd1;
    tok_lo      = '0;
    want_tok_hi = 1'b0;
  endtask

  // Read one byte from the window and append it at the write pointer. Offset
  // zero reads the slot about to be overwritten, i.e. a full window back.
  function automatic logic [7:0] copy_byte(input logic [9:0] ofs);
    logic [9:0] src;
    logic [7:0] v;
    src = win_ptr + ofs;
    v = win_hist[src];
    win_hist[win_ptr] = v;
    win_ptr = win_ptr + 10'd1;
    return v;
  endfunction

  // Work out the pairs one compressed byte releases and queue them.
  task automatic decode_byte(input in_t item);
    logic [15:0] tok;
    logic [9:0]  ofs;
    int          len;
    int          n_pairs;
    out_t        r;
    tok = {item.in_byte, tok_lo};
    if (flag_sr == 9'd1) begin
      // Flag byte: store it reversed so the MSB is consumed first.
      for (int i = 0; i < 8; i++) begin
        flag_sr[i] = item.in_byte[7-i];
      end
      flag_sr[8] = 1'b1;
    end else if (want_tok_hi) begin
      len = int'(tok[15:10]) + COUNT_BIAS;
      ofs = tok[9:0];
      n_pairs = (len + 1) / 2;
      for (int k = 0; k < n_pairs; k++) begin
        r = '0;
        r.first_byte = copy_byte(ofs);
        if (2 * k + 1 < len) begin
          r.second_byte = copy_byte(ofs);
          r.byte_count  = 2'd2;
        end else begin
          r.byte_count = 2'd1;
        end
        r.run_last = (k == n_pairs - 1);
        pending_pairs.push_back(r);
      end
      want_tok_hi = 1'b0;
      flag_sr = flag_sr >> 1;
    end else if (flag_sr[0]) begin
      win_hist[win_ptr] = item.in_byte;
      win_ptr = win_ptr + 10'd1;
      r = '0;
      r.first_byte = item.in_byte;
      r.byte_count = 2'd1;
      r.run_last   = 1'b1;
      pending_pairs.push_back(r);
      flag_sr = flag_sr >> 1;
    end else begin
      // Token low byte: hold it until the high byte shows up.
      tok_lo = item.in_byte;
      want_tok_hi = 1'b1;
    end
    // Stream end drops any half token and returns to the cleared state.
    if (item.stream_end) begin
      clear_window();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b, input bit last);
    in_t it;
    it.in_byte    = b;
    it.stream_end = last;
    compressed_bytes.push_back(it);
  endtask

  // Push a two-byte token, low byte first; the end marker rides on the high byte.
  task automatic put_token(input logic [9:0] ofs, input logic [5:0] len_code,
                           input bit last);
    logic [15:0] tok;
    tok = {len_code, ofs};
    put_byte(tok[7:0], 1'b0);
    put_byte(tok[15:8], last);
  endtask

  // Build one stream of a given length. Mostly flag-driven structure with
  // tokens that look back into recent history; sometimes raw noise. The stream
  // is cut at an arbitrary byte, so the end marker lands on every kind of byte.
  task automatic put_stream(input int len, input bit noise, input bit with_end);
    logic [7:0] bytes[$];
    logic [7:0] flag;
    logic [9:0] ofs;
    logic [5:0] len_code;
    logic [15:0] tok;
    while (bytes.size() < len) begin
      flag = 8'($urandom);
      bytes.push_back(flag);
      for (int k = 7; k >= 0; k--) begin
        if (noise || flag[k]) begin
          bytes.push_back(8'($urandom));
        end else begin
          ofs = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                            : 10'(WIN - $urandom_range(1, 48));
          len_code = ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                 : 6'($urandom_range(0, 6));
          tok = {len_code, ofs};
          bytes.push_back(tok[7:0]);
          bytes.push_back(tok[15:8]);
        end
      end
    end
    while (bytes.size() > len) begin
      void'(bytes.pop_back());
    end
    for (int i = 0; i < len; i++) begin
      put_byte(bytes[i], with_end && (i == len - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: advance on the falling edge, hold while stalled
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        if ($urandom_range(0, 15) == 0) calm_in = !calm_in;
        gap_left = calm_in ? 0 : $urandom_range(0, 3);
      end
      if (in_valid_i && !in_taken) begin
        // Hold the current transfer until it is accepted.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (compressed_bytes.size() != 0) begin
        in_data_i  <= compressed_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall: random wait after each transfer, occasional stall when idle
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
        stall_left = calm_out ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!out_valid_o && !calm_out) begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, check on output transfers
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    out_t want;
    in_taken  <= rst_ni && in_valid_i && !in_stall_o;
    out_taken <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_pairs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: first %h second %h count %0d last %0b",
                     out_data_o.first_byte, out_data_o.second_byte,
                     out_data_o.byte_count, out_data_o.run_last);
          end
        end else begin
          want = pending_pairs.pop_front();
          if (out_data_o.first_byte  !== want.first_byte  ||
              out_data_o.second_byte !== want.second_byte ||
              out_data_o.byte_count  !== want.byte_count  ||
              out_data_o.run_last    !== want.run_last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected %h %h %0d %0b, got %h %h %0d %0b",
                       want.first_byte, want.second_byte, want.byte_count,
                       want.run_last, out_data_o.first_byte,
                       out_data_o.second_byte, out_data_o.byte_count,
                       out_data_o.run_last);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    clear_window();

    // Directed: two literals at the byte extremes, then six tokens.
    put_byte(8'hC0, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_token(10'd1023, 6'd63, 1'b0);  // longest copy, overlapping one back
    put_token(10'd0, 6'd0, 1'b0);      // shortest copy, a full window back
    put_token(10'd1022, 6'd1, 1'b0);   // odd count ends on a single byte
    put_token(10'd512, 6'd2, 1'b0);    // reach into never-written history
    put_token(10'd1000, 6'd3, 1'b0);
    put_token(10'd1020, 6'd0, 1'b1);   // stream end on a token high byte
    // Stream end on a flag byte, then on a token low byte (token dropped).
    put_byte(8'h55, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'h12, 1'b1);
    // Fresh stream after the reset, ending on a literal.
    put_byte(8'hFF, 1'b0);
    put_byte(8'hA5, 1'b0);
    put_byte(8'h5A, 1'b1);

    // Random streams; some run on without an end marker.
    begin : random_part
      int n_sent;
      int len;
      n_sent = 0;
      while (n_sent < 105) begin
        len = $urandom_range(4, 40);
        if (len > 105 - n_sent) len = 105 - n_sent;
        put_stream(len, $urandom_range(0, 5) == 0, $urandom_range(0, 2) != 0);
        n_sent += len;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every byte accepted, every pair returned, then a short tail.
    while (compressed_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
